@@ rtl/core/tlbrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbrr_pkg: shared types and constants of the round-robin tlb fill unit
// Table size, command codes, beat payload structs and the control group
// between the sequencer and the sweep unit.
// ----------------------------------------------------------------------------
package tlbrr_pkg;

	// table geometry
	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// field widths
	localparam int PAGE_W    = 20;
	localparam int SLOT_W    = 6;
	localparam int CLEARED_W = 7;
	localparam int TOTAL_W   = 32;

	// command codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_FLUSH  = 2'd1;
	localparam logic [1:0] OP_INVAL  = 2'd2;

	// input beat
	typedef struct packed {
		logic [1:0]        op;
		logic [PAGE_W-1:0] vpage;
		logic [PAGE_W-1:0] frame;
		logic              read_only;
	} cmd_t;

	// result beat
	typedef struct packed {
		logic [SLOT_W-1:0]    slot;
		logic                 replaced;
		logic [CLEARED_W-1:0] cleared;
		logic [TOTAL_W-1:0]   replace_total;
		logic [TOTAL_W-1:0]   free_total;
	} rsp_t;

	// one table entry as held in the ram
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [PAGE_W-1:0] frame;
		logic              dirty;
	} entry_t;

	// sequencer controls for the sweep unit
	typedef struct packed {
		logic clear;
		logic issue;
		logic flush;
	} sweep_ctl_t;

endpackage

@@ rtl/core/tlbrr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbrr_ram: generic simple dual-port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlbrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/tlbrr_sweep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbrr_sweep: shared match and count unit
// Decides per swept entry whether it is cleared and keeps the running count
// of cleared entries for the current flush or invalidate.
// ----------------------------------------------------------------------------
module tlbrr_sweep
	import tlbrr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  sweep_ctl_t        ctl,
	input  logic              valid_bit,
	input  logic [PAGE_W-1:0] frame_rd,
	input  logic [PAGE_W-1:0] frame_key,
	output logic              hit,
	output logic [CNT_W-1:0]  cnt_next
);

	logic [CNT_W-1:0] cnt_q;

	// match: flush takes every valid entry, invalidate only matching frames
	always_comb begin
		hit      = ctl.issue && valid_bit && (ctl.flush || (frame_rd == frame_key));
		cnt_next = cnt_q + CNT_W'(hit);
	end

	// cleared count accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.clear) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_next;
		end
	end

endmodule

@@ rtl/core/tlb_round_robin_fill_unit.sv @@
`timescale 1ns / 1ps
// Insert and unused op: busy in ST_INS after the accepting edge, done strobes
//   in the following cycle as busy drops; a new beat may be taken then.
// Flush and invalidate by frame: one ram read per entry through the shared
//   match unit, busy through ST_SWEEP and ST_DRAIN; no new beat while busy.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset clears all valid marks, pointer and totals at once; no clearing pass.
// ----------------------------------------------------------------------------
// tlb_round_robin_fill_unit: round-robin tlb fill with flush and invalidate
// Small sequencer driving an entry ram, per-entry valid flops and a shared
// match and count unit that sweeps the table one entry a cycle.
// ----------------------------------------------------------------------------
module tlb_round_robin_fill_unit
	import tlbrr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_INS   = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	logic [1:0]         state_q;
	cmd_t               cmd_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [IDX_W-1:0]   idx_q;
	logic [ENTRIES-1:0] valid_q;
	logic [TOTAL_W-1:0] replace_q;
	logic [TOTAL_W-1:0] free_q;
	logic               issue_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               done_q;
	rsp_t               rsp_q;

	logic       accept;
	logic       do_insert;
	entry_t     wr_entry;
	entry_t     rd_entry;
	sweep_ctl_t sw_ctl;
	logic       sw_hit;
	logic [CNT_W-1:0] sw_cnt;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign do_insert = (state_q == ST_INS) && (cmd_q.op == OP_INSERT);

	// entry written by an insert
	always_comb begin
		wr_entry.page  = cmd_q.vpage;
		wr_entry.frame = cmd_q.frame;
		wr_entry.dirty = !cmd_q.read_only;
	end

	// entry store
	tlbrr_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (do_insert),
		.waddr (ptr_q),
		.wdata (wr_entry),
		.re    (state_q == ST_SWEEP),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	// sweep controls
	always_comb begin
		sw_ctl.clear = accept;
		sw_ctl.issue = issue_s1;
		sw_ctl.flush = (cmd_q.op == OP_FLUSH);
	end

	tlbrr_sweep u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (sw_ctl),
		.valid_bit (valid_q[idx_s1]),
		.frame_rd  (rd_entry.frame),
		.frame_key (cmd_q.frame),
		.hit       (sw_hit),
		.cnt_next  (sw_cnt)
	);

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
	end

	// sweep read stage
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	// sequencer, valid marks and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ptr_q     <= '0;
			idx_q     <= '0;
			valid_q   <= '0;
			replace_q <= '0;
			free_q    <= '0;
			issue_s1  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			// result beat follows the last working cycle
			done_q   <= (state_q == ST_INS) || (state_q == ST_DRAIN);
			issue_s1 <= (state_q == ST_SWEEP);
			if (sw_hit) begin
				valid_q[idx_s1] <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if ((cmd.op == OP_FLUSH) || (cmd.op == OP_INVAL)) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_INS;
						end
					end
				end
				ST_INS: begin
					if (do_insert) begin
						valid_q[ptr_q] <= 1'b1;
						ptr_q <= (ptr_q == IDX_LAST) ? '0 : ptr_q + 1'b1;
						if (valid_q[ptr_q]) begin
							replace_q <= replace_q + 1'b1;
						end else begin
							free_q <= free_q + 1'b1;
						end
					end
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (state_q == ST_INS) begin
			rsp_q.cleared <= '0;
			if (do_insert) begin
				rsp_q.slot     <= SLOT_W'(ptr_q);
				rsp_q.replaced <= valid_q[ptr_q];
				rsp_q.replace_total <= valid_q[ptr_q] ? replace_q + 1'b1 : replace_q;
				rsp_q.free_total    <= valid_q[ptr_q] ? free_q : free_q + 1'b1;
			end else begin
				rsp_q.slot          <= '0;
				rsp_q.replaced      <= 1'b0;
				rsp_q.replace_total <= replace_q;
				rsp_q.free_total    <= free_q;
			end
		end else if (state_q == ST_DRAIN) begin
			rsp_q.slot          <= '0;
			rsp_q.replaced      <= 1'b0;
			rsp_q.cleared       <= CLEARED_W'(sw_cnt);
			rsp_q.replace_total <= replace_q;
			rsp_q.free_total    <= free_q;
		end
	end

`ifndef SYNTH
	// a result beat only follows a cycle of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without preceding work");

	// an accepted beat makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	// insert work always ends in a result beat
	a_ins_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |=> (done && !busy))
		else $error("insert did not complete in one cycle");

	// no entry is matched outside a sweep
	a_hit_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sw_hit |-> ((state_q == ST_SWEEP) || (state_q == ST_DRAIN)))
		else $error("entry cleared outside a sweep");

	// the cleared count never exceeds the table size
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue_s1 |-> (sw_cnt <= CNT_W'(ENTRIES)))
		else $error("cleared count out of range");
`endif

endmodule
